[hw/rtl/sroc_pkg.sv]
// sroc_pkg: shared types, codes and constants for the sequence range occupancy table.
// No dependencies.
`timescale 1ns / 1ps
package sroc_pkg;
  localparam int SEQ_LENGTH_DEF  = 1024;
  localparam int MAX_STRANDS_DEF = 16;
  localparam int POS_W = 10;
  localparam int QTY_W = 16;
  localparam int STRAND_W = 4;
  localparam int SITE_W = 18;

  typedef enum logic [2:0] {
    FN_ADD_RANGE = 3'd0, FN_REM_RANGE = 3'd1, FN_ADD_SEQ = 3'd2, FN_REM_SEQ = 3'd3,
    FN_EXTEND = 3'd4, FN_RELEASE = 3'd5, FN_SITES = 3'd6, FN_AVAIL = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_RANGE = 3'd1, ST_FEW = 3'd2, ST_TAKEN = 3'd3, ST_STRAND = 3'd4
  } status_t;

  // Saturating add of a +1/-1 step to a 16-bit signed count.
  function automatic logic signed [15:0] sat_step(logic signed [15:0] v, logic up);
    logic signed [16:0] s;
    s = up ? {v[15], v} + 17'sd1 : {v[15], v} - 17'sd1;
    if (s > 17'sd32767) return 16'sh7fff;
    if (s < -17'sd32768) return 16'sh8000;
    return s[15:0];
  endfunction
endpackage

[hw/rtl/sroc_if.sv]
// sroc_in_if / sroc_out_if: valid/ready channels of the table unit.
// No dependencies.
`timescale 1ns / 1ps
interface sroc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [9:0] first_pos;
  logic [9:0] last_pos;
  logic [15:0] quantity;
  logic [3:0] strand;
  modport source(output valid, func, first_pos, last_pos, quantity, strand, input ready);
  modport sink(input valid, func, first_pos, last_pos, quantity, strand, output ready);
endinterface

interface sroc_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic signed [17:0] site_count;
  modport source(output valid, status, site_count, input ready);
  modport sink(input valid, status, site_count, output ready);
endinterface

[hw/rtl/sroc_store.sv]
// sroc_store: per-position memory of occupancy, segment count and strand marks.
// Depends on sroc_pkg. One read and one write port, registered read data.
`timescale 1ns / 1ps
module sroc_store #(
  parameter int DEPTH = sroc_pkg::SEQ_LENGTH_DEF,
  parameter int NSTR = sroc_pkg::MAX_STRANDS_DEF,
  parameter int AW = sroc_pkg::POS_W
) (
  input  logic clk,
  input  logic [AW-1:0] rd_addr,
  output logic [32+NSTR-1:0] rd_data,
  input  logic we,
  input  logic [AW-1:0] wr_addr,
  input  logic [32+NSTR-1:0] wr_data
);
  logic [32+NSTR-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

[hw/rtl/sequence_range_occupancy_table_unit.sv]
// sequence_range_occupancy_table_unit: top level, sequencer plus shared update/compare unit.
// Depends on sroc_pkg, sroc_if, sroc_store.
//
//  channel | dir | payload
//  in_     | in  | func, first_pos, last_pos, quantity, strand
//  out_    | out | status, site_count
//
// After reset a clearing pass writes zero to every position; no item is taken meanwhile.
// Range ops walk one position at a time from first to last through the store;
// release walks all SEQ_LENGTH positions; extend visits its single position;
// scalar ops and rejected items skip the walk.
// Each position passes through a read step, a wait step for the registered read data and a
// write-back step.
// A finished result sits in the output register; the next item is taken meanwhile.
// The sequencer stalls in its last step only while an older result still waits.
`timescale 1ns / 1ps
module sequence_range_occupancy_table_unit #(
  parameter int SEQ_LENGTH = sroc_pkg::SEQ_LENGTH_DEF,
  parameter int MAX_STRANDS = sroc_pkg::MAX_STRANDS_DEF
) (
  input logic clk,
  input logic rst_n,
  sroc_in_if.sink in_ch,
  sroc_out_if.source out_ch
);
  import sroc_pkg::*;
  localparam int AW = (SEQ_LENGTH > 1) ? $clog2(SEQ_LENGTH) : 1;
  localparam int DW = 32 + MAX_STRANDS;

  typedef enum logic [5:0] {
    S_CLR = 6'b000001, S_IDLE = 6'b000010, S_RD = 6'b000100,
    S_WAIT = 6'b001000, S_WR = 6'b010000, S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW:0] addr_r, addr_nxt, last_r;
  func_t func_r;
  logic [STRAND_W-1:0] strand_r;
  logic signed [15:0] acc_r, acc_nxt;
  logic acc_vld_r, acc_vld_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [2:0] st_r, st_nxt;     // status of the item in progress
  logic [2:0] ost_r, ost_nxt;
  logic signed [17:0] osite_r, osite_nxt;
  logic ovalid_r, ovalid_nxt;
  logic [DW-1:0] rd_data, wr_data;
  logic we;

  sroc_store #(.DEPTH(SEQ_LENGTH), .NSTR(MAX_STRANDS), .AW(AW)) u_store (
    .clk, .rd_addr(addr_r[AW-1:0]), .rd_data, .we, .wr_addr(addr_r[AW-1:0]), .wr_data
  );

  logic signed [15:0] occ_q, seg_q;
  logic [MAX_STRANDS-1:0] mk_q, sbit;
  assign occ_q = rd_data[15:0];
  assign seg_q = rd_data[31:16];
  assign mk_q = rd_data[DW-1:32];
  assign sbit = (MAX_STRANDS)'(1) << strand_r;

  logic accept;
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.status = ost_r;
  assign out_ch.site_count = osite_r;

  // Write-back value of the current position.
  always_comb begin
    we = 1'b0;
    wr_data = rd_data;
    if (state_r == S_CLR) begin
      we = 1'b1;
      wr_data = '0;
    end else if (state_r == S_WR) begin
      case (func_r)
        FN_ADD_RANGE: begin we = 1'b1; wr_data[15:0] = sat_step(occ_q, 1'b1); end
        FN_REM_RANGE: begin we = 1'b1; wr_data[15:0] = sat_step(occ_q, 1'b0); end
        FN_EXTEND: if ((mk_q & sbit) == '0) begin
          we = 1'b1;
          wr_data[15:0] = sat_step(occ_q, 1'b0);
          wr_data[31:16] = sat_step(seg_q, 1'b1);
          wr_data[DW-1:32] = mk_q | sbit;
        end
        FN_RELEASE: begin
          we = 1'b1;
          wr_data[15:0] = sat_step(occ_q, 1'b1);
          wr_data[31:16] = sat_step(seg_q, 1'b0);
          wr_data[DW-1:32] = mk_q & ~sbit;
        end
        default: ;
      endcase
    end
  end

  logic [16:0] seq_sum;
  logic signed [17:0] site_v;
  always_comb begin
    state_nxt = state_r; addr_nxt = addr_r; acc_nxt = acc_r; acc_vld_nxt = acc_vld_r;
    seq_nxt = seq_r; st_nxt = st_r; ost_nxt = ost_r; osite_nxt = osite_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    seq_sum = '0; site_v = '0;
    case (state_r)
      S_CLR: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == (AW+1)'(SEQ_LENGTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (accept) begin
        st_nxt = ST_OK; acc_vld_nxt = 1'b0;
        addr_nxt = (AW+1)'(in_ch.first_pos);
        state_nxt = S_RD;
        case (func_t'(in_ch.func))
          FN_ADD_SEQ: begin
            seq_sum = {1'b0, seq_r} + {1'b0, in_ch.quantity};
            seq_nxt = seq_sum[16] ? 16'hffff : seq_sum[15:0];
            state_nxt = S_DONE;
          end
          FN_REM_SEQ: begin
            if (in_ch.quantity > seq_r) st_nxt = ST_FEW;
            else seq_nxt = seq_r - in_ch.quantity;
            state_nxt = S_DONE;
          end
          FN_EXTEND: begin
            if (32'(in_ch.first_pos) >= SEQ_LENGTH) begin
              st_nxt = ST_RANGE; state_nxt = S_DONE;
            end else if (32'(in_ch.strand) >= MAX_STRANDS) begin
              st_nxt = ST_STRAND; state_nxt = S_DONE;
            end
          end
          FN_RELEASE: begin
            addr_nxt = '0;
            if (32'(in_ch.strand) >= MAX_STRANDS) begin
              st_nxt = ST_STRAND; state_nxt = S_DONE;
            end else if (seq_r != 16'hffff) seq_nxt = seq_r + 16'd1;
          end
          default: if (in_ch.first_pos > in_ch.last_pos ||
                       32'(in_ch.last_pos) >= SEQ_LENGTH) begin
            st_nxt = ST_RANGE; state_nxt = S_DONE;
          end
        endcase
      end
      S_RD: state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_WR;
      S_WR: begin
        // shared compare for the queries
        if (func_r == FN_SITES && (!acc_vld_r || seg_q < acc_r)) acc_nxt = seg_q;
        if (func_r == FN_AVAIL && (!acc_vld_r || occ_q > acc_r)) acc_nxt = occ_q;
        acc_vld_nxt = 1'b1;
        if (func_r == FN_EXTEND && (mk_q & sbit) != '0) st_nxt = ST_TAKEN;
        if (func_r == FN_EXTEND || addr_r == last_r) state_nxt = S_DONE;
        else begin addr_nxt = addr_r + 1'b1; state_nxt = S_RD; end
      end
      S_DONE: if (!(ovalid_r && !out_ch.ready)) begin
        ost_nxt = st_r;
        osite_nxt = '0;
        if (st_r == ST_OK && func_r == FN_SITES)
          osite_nxt = $signed({2'b00, seq_r}) + 18'(acc_r);
        else if (st_r == ST_OK && func_r == FN_AVAIL) begin
          site_v = $signed({2'b00, seq_r}) - 18'(acc_r);
          osite_nxt = site_v[17] ? '0 : site_v;
        end
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; addr_r <= '0; seq_r <= '0; ovalid_r <= 1'b0; acc_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt; addr_r <= addr_nxt; seq_r <= seq_nxt;
      ovalid_r <= ovalid_nxt; acc_vld_r <= acc_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; st_r <= st_nxt; ost_r <= ost_nxt; osite_r <= osite_nxt;
    if (accept) begin
      func_r <= func_t'(in_ch.func);
      strand_r <= in_ch.strand;
      last_r <= (func_t'(in_ch.func) == FN_RELEASE) ? (AW+1)'(SEQ_LENGTH - 1)
                                                    : (AW+1)'(in_ch.last_pos);
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ch.ready) |=> ovalid_r && $stable(osite_r)) else $error("result lost");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
endmodule
